// File: design/bis_pkg.sv
// shared constants, types and helpers of the bilinear image scaler
`default_nettype none
package bis_pkg;
  localparam int MAX_DIM    = 256;
  localparam int MAX_PIXELS = 16384;
  localparam int DIM_W      = 9;
  localparam int COORD_W    = 8;
  localparam int IDX_W      = 14;
  localparam int FRAC_BITS  = 16;
  localparam int STEP_W     = DIM_W + FRAC_BITS;
  localparam int POS_W      = COORD_W + STEP_W;
  localparam int ADDR_W     = COORD_W + DIM_W;
  localparam int CNT_W      = 5;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SCALE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// File: design/bis_if.sv
// channel interfaces of the scaler: request words in, pixel words out
`default_nettype none
interface bis_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [13:0] load_index;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic [7:0]  in_alpha;
  logic [7:0]  out_col;
  logic [7:0]  out_row;
  modport source (output valid, opcode, load_index, in_red, in_green, in_blue, in_alpha,
                  out_col, out_row, input ready);
  modport sink (input valid, opcode, load_index, in_red, in_green, in_blue, in_alpha,
                out_col, out_row, output ready);
endinterface

interface bis_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] res_red;
  logic [7:0] res_green;
  logic [7:0] res_blue;
  logic [7:0] res_alpha;
  modport source (output valid, res_red, res_green, res_blue, res_alpha, input ready);
  modport sink (input valid, res_red, res_green, res_blue, res_alpha, output ready);
endinterface
`default_nettype wire

// File: design/bis_div.sv
// restoring divider for the 9.16 step, one quotient bit per cycle
`default_nettype none
module bis_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bis_pkg::DIM_W-1:0]  num,
  input  wire logic [bis_pkg::DIM_W-1:0]  den,
  output logic                            busy,
  output logic [bis_pkg::STEP_W-1:0]      quo
);
  import bis_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [DIM_W-1:0] rem;
  logic [DIM_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, quo[STEP_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      quo  <= STEP_W'(1) << FRAC_BITS;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEP_W - 1);
      quo  <= {num, FRAC_BITS'(0)};
    end else if (busy) begin
      quo <= {quo[STEP_W-2:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? DIM_W'(rem_sh - {1'b0, den}) : DIM_W'(rem_sh);
    end
  end
endmodule
`default_nettype wire

// File: design/bilinear_image_scaler.sv
// top level: bilinear rgba8 scaler with replicated pixel store and five-stage pipeline
// a scale word is registered through stages one to five and appears at the output from stage 5
// throughput: one word per cycle while the dividers are idle; the whole pipeline holds while a result waits
// after a register write the two step dividers run with the input held off
// reset: dimensions return to 64 with step 1.0 ready at once; the store keeps no reset
`default_nettype none
module bilinear_image_scaler (
  input  wire logic        clk,
  input  wire logic        rst,
  bis_in_if.sink           pix_in,
  bis_out_if.source        pix_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bis_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [DIM_W-1:0] sw, sh, dw, dh;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(64);
      src_height <= DIM_W'(64);
      dst_width  <= DIM_W'(64);
      dst_height <= DIM_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_WIDTH:  src_width  <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[DIM_W-1:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[DIM_W-1:0];
        REG_DST_HEIGHT: dst_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SRC_WIDTH:  prdata = 32'(src_width);
      REG_SRC_HEIGHT: prdata = 32'(src_height);
      REG_DST_WIDTH:  prdata = 32'(dst_width);
      REG_DST_HEIGHT: prdata = 32'(dst_height);
      default:        prdata = '0;
    endcase
  end

  // zero reads as one, oversize as the maximum
  assign sw = clamp_dim(src_width);
  assign sh = clamp_dim(src_height);
  assign dw = clamp_dim(dst_width);
  assign dh = clamp_dim(dst_height);

  // step dividers restart the cycle after any register write
  div_ctl_t          dx_ctl, dy_ctl;
  logic              start_q, busy;
  logic [STEP_W-1:0] step_x, step_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_q <= 1'b0;
    end else begin
      start_q <= cfg_wr;
    end
  end

  assign dx_ctl.start = start_q;
  assign dy_ctl.start = start_q;

  bis_div u_div_x (
    .clk (clk), .rst (rst), .start (dx_ctl.start), .num (sw), .den (dw),
    .busy (dx_ctl.busy), .quo (step_x)
  );
  bis_div u_div_y (
    .clk (clk), .rst (rst), .start (dy_ctl.start), .num (sh), .den (dh),
    .busy (dy_ctl.busy), .quo (step_y)
  );

  assign busy = start_q || dx_ctl.busy || dy_ctl.busy;

  // pipeline moves whenever the output register is free or being emptied
  logic adv;
  logic v1, v2, v3, v4, v5;

  assign adv          = !v5 || pix_out.ready;
  assign pix_in.ready = adv && !busy;

  // stage 1: captured request word
  op_t                op1;
  logic [IDX_W-1:0]   idx1;
  logic [31:0]        pix1;
  logic [COORD_W-1:0] col1, row1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pix_in.valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1  <= op_t'(pix_in.opcode);
      idx1 <= pix_in.load_index;
      pix1 <= {pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red};
      col1 <= pix_in.out_col;
      row1 <= pix_in.out_row;
    end
  end

  // load words travel alongside so the store is written at the read stage, keeping order
  logic             ld2, ld3;
  logic [IDX_W-1:0] idx2, idx3;
  logic [31:0]      pix2, pix3;

  always_ff @(posedge clk) begin
    if (rst) begin
      ld2 <= 1'b0;
      ld3 <= 1'b0;
    end else if (adv) begin
      ld2 <= v1 && op1 == OP_LOAD;
      ld3 <= ld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx2 <= idx1;
      pix2 <= pix1;
      idx3 <= idx2;
      pix3 <= pix2;
    end
  end

  // pixel store: one copy per neighbour so each gets its own read port
  logic [31:0] mem0 [MAX_PIXELS];
  logic [31:0] mem1 [MAX_PIXELS];
  logic [31:0] mem2 [MAX_PIXELS];
  logic [31:0] mem3 [MAX_PIXELS];

  always_ff @(posedge clk) begin
    if (adv && ld3) begin
      mem0[idx3] <= pix3;
      mem1[idx3] <= pix3;
      mem2[idx3] <= pix3;
      mem3[idx3] <= pix3;
    end
  end

  // stage 2: source positions in 17.16
  logic [POS_W-1:0] posx2, posy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && op1 == OP_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      posx2 <= POS_W'(col1) * POS_W'(step_x);
      posy2 <= POS_W'(row1) * POS_W'(step_y);
    end
  end

  // stage 3: clamped neighbours, linear addresses and weights
  localparam int IP_W = POS_W - FRAC_BITS;
  logic [IP_W-1:0]    ipx, ipy;
  logic [COORD_W-1:0] xmax, ymax, x0, x1, y0, y1;
  logic [7:0]         fx, fy;
  logic [8:0]         gx, gy;
  logic [ADDR_W-1:0]  a3 [4];
  logic [8:0]         w3 [4];
  logic [ADDR_W-1:0]  row0, row1b;
  logic [17:0]        p00, p10, p01, p11;

  always_comb begin
    xmax = COORD_W'(sw - DIM_W'(1));
    ymax = COORD_W'(sh - DIM_W'(1));
    ipx  = posx2[POS_W-1:FRAC_BITS];
    ipy  = posy2[POS_W-1:FRAC_BITS];
    x0   = (ipx > IP_W'(xmax)) ? xmax : COORD_W'(ipx);
    y0   = (ipy > IP_W'(ymax)) ? ymax : COORD_W'(ipy);
    // neighbour past the edge sticks to the edge
    x1   = (x0 == xmax) ? xmax : x0 + COORD_W'(1);
    y1   = (y0 == ymax) ? ymax : y0 + COORD_W'(1);
    fx   = posx2[FRAC_BITS-1:FRAC_BITS-8];
    fy   = posy2[FRAC_BITS-1:FRAC_BITS-8];
    gx   = 9'd256 - 9'(fx);
    gy   = 9'd256 - 9'(fy);
    row0  = ADDR_W'(y0) * ADDR_W'(sw);
    row1b = ADDR_W'(y1) * ADDR_W'(sw);
    p00  = 18'(gx) * 18'(gy);
    p10  = 18'(fx) * 18'(gy);
    p01  = 18'(gx) * 18'(fy);
    p11  = 18'(fx) * 18'(fy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3[0] <= row0 + ADDR_W'(x0);
      a3[1] <= row0 + ADDR_W'(x1);
      a3[2] <= row1b + ADDR_W'(x0);
      a3[3] <= row1b + ADDR_W'(x1);
      w3[0] <= p00[16:8];
      w3[1] <= p10[16:8];
      w3[2] <= p01[16:8];
      w3[3] <= p11[16:8];
    end
  end

  // stage 4: registered store reads; an address past the store reads zero
  logic [31:0] d4 [4];
  logic [3:0]  z4;
  logic [8:0]  w4 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4[0] <= mem0[a3[0][IDX_W-1:0]];
      d4[1] <= mem1[a3[1][IDX_W-1:0]];
      d4[2] <= mem2[a3[2][IDX_W-1:0]];
      d4[3] <= mem3[a3[3][IDX_W-1:0]];
      for (int k = 0; k < 4; k++) begin
        z4[k] <= a3[k] >= ADDR_W'(MAX_PIXELS);
        w4[k] <= w3[k];
      end
    end
  end

  // stage 5: weighted sums per channel into the output register
  logic [7:0]  chan [4][4];
  logic [18:0] sum [4];
  logic [7:0]  res5 [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 4; c++) begin
        chan[c][k] = z4[k] ? 8'd0 : d4[k][8*c +: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      sum[c] = 19'(17'(chan[c][0]) * 17'(w4[0])) + 19'(17'(chan[c][1]) * 17'(w4[1]))
             + 19'(17'(chan[c][2]) * 17'(w4[2])) + 19'(17'(chan[c][3]) * 17'(w4[3]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        res5[c] <= sum[c][15:8];
      end
    end
  end

  assign pix_out.valid     = v5;
  assign pix_out.res_red   = res5[0];
  assign pix_out.res_green = res5[1];
  assign pix_out.res_blue  = res5[2];
  assign pix_out.res_alpha = res5[3];

  // no word enters while a step is being recomputed
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pix_in.ready) else $error("input open during step division");

  // a register write always restarts the dividers
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy) else $error("register write did not start division");

  // a held pipeline keeps its middle stages
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(v3) && $stable(v4))) else $error("stage lost during stall");
endmodule
`default_nettype wire
